FILE: src/erh_pkg.sv
// Shared types and constants for the exception range handler lookup block.
// Used by the front, queue and back modules; depends on nothing else.
`default_nettype none

package erh_pkg;

    localparam int SLOT_W   = 4;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 40;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // Decoded command passed from the front to the back through the queue.
    // For a lookup, lo carries the offset being searched for.
    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  lo;
        logic [WORD_W-1:0]  hi;
        logic [WORD_W-1:0]  handler;
    } t_cmd;

    // One stored table entry; the span is worked out when the entry is written.
    typedef struct packed {
        logic [WORD_W-1:0]  lo;
        logic [WORD_W-1:0]  hi;
        logic [WORD_W-1:0]  span;
        logic [WORD_W-1:0]  handler;
    } t_entry;

endpackage

`default_nettype wire

FILE: src/erh_front.sv
// Input front end: accepts stream transfers and decodes them into commands.
// Depends on erh_pkg; feeds erh_queue.
`default_nettype none

module erh_front #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [erh_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                           s_axis_tuser,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output erh_pkg::t_cmd                       o_cmd
);
    import erh_pkg::*;

    logic slot_ok;
    logic take;

    always_comb begin
        o_cmd.op      = t_op'(s_axis_tuser);
        o_cmd.slot    = s_axis_tdata[3:0];
        o_cmd.hi      = s_axis_tdata[67:36];
        o_cmd.handler = s_axis_tdata[99:68];
        if (s_axis_tuser == OP_LOOKUP) begin
            o_cmd.lo = s_axis_tdata[131:100];
        end else begin
            o_cmd.lo = s_axis_tdata[35:4];
        end
    end

    // Writes to slots beyond the table are accepted and dropped here.
    assign slot_ok       = (32'(s_axis_tdata[3:0]) < 32'(TABLE_DEPTH));
    assign s_axis_tready = !i_q_full;
    assign take          = s_axis_tvalid && !i_q_full;
    assign o_push        = take && ((o_cmd.op == OP_LOOKUP) || slot_ok);

endmodule

`default_nettype wire

FILE: src/erh_queue.sv
// Short command queue between the front end and the table engine.
// Depends on erh_pkg.
`default_nettype none

module erh_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire erh_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output erh_pkg::t_cmd       o_head,
    output logic                o_full,
    output logic                o_empty
);
    import erh_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/erh_back.sv
// Table engine: holds the range table, carries out writes and scans the table
// one entry per cycle for lookups, then loads the output register.
// Depends on erh_pkg; takes commands from erh_queue.
`default_nettype none

module erh_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [erh_pkg::COUNT_W-1:0]    i_cfg_wr_data,
    input  wire erh_pkg::t_cmd                  i_head,
    input  wire logic                           i_q_empty,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_found,
    output logic [erh_pkg::WORD_W-1:0]          o_target_pc,
    output logic [erh_pkg::SLOT_W-1:0]          o_matched_entry
);
    import erh_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_entry               r_mem [TABLE_DEPTH];
    t_entry               r_rd_data;
    t_state               r_state;
    logic [COUNT_W-1:0]   r_entry_count;
    logic [WORD_W-1:0]    r_pc;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     r_last;
    logic                 r_hit;
    logic [WORD_W-1:0]    r_min_span;
    logic [WORD_W-1:0]    r_best_handler;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 r_out_valid;
    logic                 r_found;
    logic [WORD_W-1:0]    r_target_pc;
    logic [SLOT_W-1:0]    r_matched_entry;

    logic [IDX_W-1:0]     rd_addr;
    logic                 covers;
    logic                 better;
    logic                 out_free;
    t_entry               wr_entry;

    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if ((r_state == S_SCAN) && (r_cur != r_last)) begin
            rd_addr = r_cur + 1'b1;
        end else begin
            rd_addr = '0;
        end
        covers = (r_pc >= r_rd_data.lo) && (r_pc <= r_rd_data.hi);
        // Ties on span go to the later entry, hence the non-strict compare.
        better = covers && (!r_hit || (r_rd_data.span <= r_min_span));
        wr_entry.lo      = i_head.lo;
        wr_entry.hi      = i_head.hi;
        wr_entry.span    = i_head.hi - i_head.lo;
        wr_entry.handler = i_head.handler;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.op == OP_WRITE)) begin
            r_mem[IDX_W'(i_head.slot)] <= wr_entry;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_hit         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entry_count <= i_cfg_wr_data;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_head.op == OP_LOOKUP)) begin
                        r_pc           <= i_head.lo;
                        r_hit          <= 1'b0;
                        r_min_span     <= '0;
                        r_best_handler <= '0;
                        r_best_idx     <= '0;
                        r_cur          <= '0;
                        if (32'(r_entry_count) >= 32'(TABLE_DEPTH)) begin
                            r_last <= IDX_W'(TABLE_DEPTH - 1);
                        end else begin
                            r_last <= IDX_W'(r_entry_count - 1'b1);
                        end
                        if (r_entry_count == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (better) begin
                        r_hit          <= 1'b1;
                        r_min_span     <= r_rd_data.span;
                        r_best_handler <= r_rd_data.handler;
                        r_best_idx     <= r_cur;
                    end
                    if (r_cur == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_found         <= r_hit;
                        r_target_pc     <= r_hit ? r_best_handler : '0;
                        r_matched_entry <= r_hit ? SLOT_W'(r_best_idx) : '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_target_pc     = r_target_pc;
    assign o_matched_entry = r_matched_entry;

endmodule

`default_nettype wire

FILE: src/exception_range_handler_lookup_core.sv
// Top level of the exception range handler lookup block.
// Depends on erh_pkg, erh_front, erh_queue and erh_back.
//
// Usage: items arrive on the s_axis channel. tuser selects the operation
// (low writes a table entry, high looks up an offset). A write stores start,
// end and handler in the given slot and gives no result. A lookup returns one
// transfer on m_axis: tuser is the found flag, tdata carries the handler
// offset and the index of the narrowest covering entry (both zero on a miss).
// The entry_count register is written through i_cfg_wr_en / i_cfg_wr_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Lookups search the first entry_count entries, at most
// TABLE_DEPTH. A two-entry command queue sits in front of the table engine.
// A write is stored when the engine pops it. For a lookup the engine issues
// the first table read, scans the entries through the single registered
// read port, then loads the result.
// After reset the table contents are undefined and entry_count is zero.
// If the receiver stalls, the result waits in the output register; the
// engine holds the next lookup and the queue keeps accepting until full.
`default_nettype none

module exception_range_handler_lookup_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [erh_pkg::COUNT_W-1:0]    i_cfg_wr_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[3:0], range_start[35:4], range_end[67:36],
    // handler_target[99:68], lookup_pc[131:100], zeros above
    input  wire logic [erh_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // target_pc[31:0], matched_entry[35:32], zeros above
    output logic [erh_pkg::M_DATA_W-1:0]        m_axis_tdata,
    // found
    output logic                                m_axis_tuser
);
    import erh_pkg::*;

    t_cmd               front_cmd;
    t_cmd               q_head;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic [WORD_W-1:0]  target_pc;
    logic [SLOT_W-1:0]  matched_entry;

    erh_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    erh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    erh_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_head          (q_head),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_found         (m_axis_tuser),
        .o_target_pc     (target_pc),
        .o_matched_entry (matched_entry)
    );

    assign m_axis_tdata = {4'b0000, matched_entry, target_pc};

endmodule

`default_nettype wire
